[rtl/ctl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctl_pkg
// Shared types and constants of the C token lexer: token kinds, lexer modes,
// keyword spellings and the entry passed from front end to back end.
// ----------------------------------------------------------------------------
package ctl_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

   localparam logic [4:0] TK_END      = 5'd0;
   localparam logic [4:0] TK_PLUS     = 5'd1;
   localparam logic [4:0] TK_MINUS    = 5'd2;
   localparam logic [4:0] TK_STAR     = 5'd3;
   localparam logic [4:0] TK_SLASH    = 5'd4;
   localparam logic [4:0] TK_LPAREN   = 5'd5;
   localparam logic [4:0] TK_RPAREN   = 5'd6;
   localparam logic [4:0] TK_LBRACE   = 5'd7;
   localparam logic [4:0] TK_RBRACE   = 5'd8;
   localparam logic [4:0] TK_LBRACKET = 5'd9;
   localparam logic [4:0] TK_RBRACKET = 5'd10;
   localparam logic [4:0] TK_SEMI     = 5'd11;
   localparam logic [4:0] TK_ASSIGN   = 5'd12;
   localparam logic [4:0] TK_LT       = 5'd13;
   localparam logic [4:0] TK_GT       = 5'd14;
   localparam logic [4:0] TK_BANG     = 5'd15;
   localparam logic [4:0] TK_EQ_EQ    = 5'd16;
   localparam logic [4:0] TK_LT_EQ    = 5'd17;
   localparam logic [4:0] TK_GT_EQ    = 5'd18;
   localparam logic [4:0] TK_NOT_EQ   = 5'd19;
   localparam logic [4:0] TK_NUMBER   = 5'd20;
   localparam logic [4:0] TK_IDENT    = 5'd21;
   localparam logic [4:0] TK_PRINT    = 5'd22;
   localparam logic [4:0] TK_VAR      = 5'd23;
   localparam logic [4:0] TK_RETURN   = 5'd24;
   localparam logic [4:0] TK_FOR      = 5'd25;
   localparam logic [4:0] TK_ERROR    = 5'd26;

   localparam logic [2:0] MODE_IDLE  = 3'd0;
   localparam logic [2:0] MODE_EQ    = 3'd1;
   localparam logic [2:0] MODE_LT    = 3'd2;
   localparam logic [2:0] MODE_GT    = 3'd3;
   localparam logic [2:0] MODE_BANG  = 3'd4;
   localparam logic [2:0] MODE_NUM   = 3'd5;
   localparam logic [2:0] MODE_IDENT = 3'd6;
   localparam logic [2:0] MODE_ERR   = 3'd7;

   // keyword spellings, first character in the lowest byte
   localparam logic [63:0] KW_PRINT_TEXT  = 64'h0000_0074_6E69_7270;
   localparam logic [63:0] KW_VAR_TEXT    = 64'h0000_0000_0072_6176;
   localparam logic [63:0] KW_RETURN_TEXT = 64'h0000_6E72_7574_6572;
   localparam logic [63:0] KW_FOR_TEXT    = 64'h0000_0000_0072_6F66;
   localparam logic [3:0]  KW_PRINT_LEN   = 4'd5;
   localparam logic [3:0]  KW_VAR_LEN     = 4'd3;
   localparam logic [3:0]  KW_RETURN_LEN  = 4'd6;
   localparam logic [3:0]  KW_FOR_LEN     = 4'd3;

   // tokens raised by one input beat: a flushed pending token, then its own
   typedef struct packed {
      logic        has_a;
      logic [4:0]  a_kind;
      logic [30:0] a_num;
      logic        a_sat;
      logic [63:0] a_text;
      logic [3:0]  a_len;
      logic        a_trunc;
      logic        has_b;
      logic [4:0]  b_kind;
   } ctl_entry_type;

endpackage
`default_nettype wire

[rtl/ctl_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctl_front
// Front end: takes one byte beat per cycle while accept is high, tracks the
// pending token and writes the tokens raised by each beat into the token queue.
// ----------------------------------------------------------------------------
module ctl_front import ctl_pkg::*; #(
   parameter int unsigned SYMBOL_CHARS = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  wire logic [7:0]    in_byte,
   input  wire logic          end_of_input,
   output ctl_entry_type      entry,
   output logic               entry_push
);

   logic [2:0]  mode_ff,  mode_in;
   logic [30:0] acc_ff,   acc_in;
   logic        clamp_ff, clamp_in;
   logic [63:0] sym_ff,   sym_in;
   logic [3:0]  cnt_ff,   cnt_in;
   logic        ovf_ff,   ovf_in;

   logic        is_space, is_digit, is_letter, is_punct;
   logic [4:0]  punct_kind;
   logic        flush_has;
   logic [4:0]  flush_kind;
   logic [4:0]  kw_kind;
   logic [34:0] acc_wide;

   always_comb begin
      is_space  = (in_byte == 8'h20) || (in_byte >= 8'h09 && in_byte <= 8'h0D);
      is_digit  = (in_byte >= 8'h30 && in_byte <= 8'h39);
      is_letter = (in_byte >= 8'h41 && in_byte <= 8'h5A) ||
                  (in_byte >= 8'h61 && in_byte <= 8'h7A);
      is_punct  = 1'b1;
      case (in_byte)
         8'h2B:   punct_kind = TK_PLUS;
         8'h2D:   punct_kind = TK_MINUS;
         8'h2A:   punct_kind = TK_STAR;
         8'h2F:   punct_kind = TK_SLASH;
         8'h28:   punct_kind = TK_LPAREN;
         8'h29:   punct_kind = TK_RPAREN;
         8'h7B:   punct_kind = TK_LBRACE;
         8'h7D:   punct_kind = TK_RBRACE;
         8'h5B:   punct_kind = TK_LBRACKET;
         8'h5D:   punct_kind = TK_RBRACKET;
         8'h3B:   punct_kind = TK_SEMI;
         default: begin
            punct_kind = TK_END;
            is_punct   = 1'b0;
         end
      endcase
   end

   // keyword lookup of the held identifier
   always_comb begin
      kw_kind = TK_IDENT;
      if (!ovf_ff) begin
         if (cnt_ff == KW_PRINT_LEN && sym_ff == KW_PRINT_TEXT) begin
            kw_kind = TK_PRINT;
         end else if (cnt_ff == KW_VAR_LEN && sym_ff == KW_VAR_TEXT) begin
            kw_kind = TK_VAR;
         end else if (cnt_ff == KW_RETURN_LEN && sym_ff == KW_RETURN_TEXT) begin
            kw_kind = TK_RETURN;
         end else if (cnt_ff == KW_FOR_LEN && sym_ff == KW_FOR_TEXT) begin
            kw_kind = TK_FOR;
         end
      end
   end

   // token held by the current mode
   always_comb begin
      flush_has = 1'b1;
      case (mode_ff)
         MODE_EQ:    flush_kind = TK_ASSIGN;
         MODE_LT:    flush_kind = TK_LT;
         MODE_GT:    flush_kind = TK_GT;
         MODE_BANG:  flush_kind = TK_BANG;
         MODE_NUM:   flush_kind = TK_NUMBER;
         MODE_IDENT: flush_kind = kw_kind;
         default: begin
            flush_kind = TK_END;
            flush_has  = 1'b0;
         end
      endcase
   end

   assign acc_wide = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + {31'b0, in_byte[3:0]};

   always_comb begin
      mode_in  = mode_ff;
      acc_in   = acc_ff;
      clamp_in = clamp_ff;
      sym_in   = sym_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;

      entry          = '0;
      entry.a_kind   = flush_kind;
      entry.a_num    = (mode_ff == MODE_NUM) ? acc_ff : 31'd0;
      entry.a_sat    = (mode_ff == MODE_NUM) ? clamp_ff : 1'b0;
      if (mode_ff == MODE_IDENT && flush_kind == TK_IDENT) begin
         entry.a_text  = sym_ff;
         entry.a_len   = cnt_ff;
         entry.a_trunc = ovf_ff;
      end

      if (end_of_input) begin
         entry.has_a  = flush_has;
         entry.has_b  = 1'b1;
         entry.b_kind = TK_END;
         mode_in      = MODE_IDLE;
         acc_in       = '0;
         clamp_in     = 1'b0;
         sym_in       = '0;
         cnt_in       = '0;
         ovf_in       = 1'b0;
      end else if (mode_ff == MODE_ERR) begin
         entry.has_a = 1'b0;
      end else if (mode_ff >= MODE_EQ && mode_ff <= MODE_BANG && in_byte == 8'h3D) begin
         entry.has_a = 1'b1;
         case (mode_ff)
            MODE_EQ:   entry.a_kind = TK_EQ_EQ;
            MODE_LT:   entry.a_kind = TK_LT_EQ;
            MODE_GT:   entry.a_kind = TK_GT_EQ;
            default:   entry.a_kind = TK_NOT_EQ;
         endcase
         mode_in = MODE_IDLE;
      end else if (mode_ff == MODE_NUM && is_digit) begin
         if (acc_wide > {4'b0, NUM_MAX}) begin
            acc_in   = NUM_MAX;
            clamp_in = 1'b1;
         end else begin
            acc_in = acc_wide[30:0];
         end
      end else if (mode_ff == MODE_IDENT && is_letter) begin
         if (cnt_ff < 4'(SYMBOL_CHARS)) begin
            sym_in = sym_ff | ({56'b0, in_byte} << {cnt_ff[2:0], 3'b000});
            cnt_in = cnt_ff + 4'd1;
         end else begin
            ovf_in = 1'b1;
         end
      end else begin
         entry.has_a = flush_has;
         mode_in     = MODE_IDLE;
         if (is_space) begin
            entry.has_b = 1'b0;
         end else if (is_punct) begin
            entry.has_b  = 1'b1;
            entry.b_kind = punct_kind;
         end else if (in_byte == 8'h3D) begin
            mode_in = MODE_EQ;
         end else if (in_byte == 8'h3C) begin
            mode_in = MODE_LT;
         end else if (in_byte == 8'h3E) begin
            mode_in = MODE_GT;
         end else if (in_byte == 8'h21) begin
            mode_in = MODE_BANG;
         end else if (is_digit) begin
            mode_in  = MODE_NUM;
            acc_in   = {27'b0, in_byte[3:0]};
            clamp_in = 1'b0;
         end else if (is_letter) begin
            mode_in = MODE_IDENT;
            sym_in  = {56'b0, in_byte};
            cnt_in  = 4'd1;
            ovf_in  = 1'b0;
         end else begin
            mode_in      = MODE_ERR;
            entry.has_b  = 1'b1;
            entry.b_kind = TK_ERROR;
         end
      end
   end

   assign entry_push = accept && (entry.has_a || entry.has_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         acc_ff   <= '0;
         clamp_ff <= 1'b0;
         sym_ff   <= '0;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         acc_ff   <= acc_in;
         clamp_ff <= clamp_in;
         sym_ff   <= sym_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule
`default_nettype wire

[rtl/ctl_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctl_queue
// Short first-in first-out queue of token entries between front and back end.
// ----------------------------------------------------------------------------
module ctl_queue import ctl_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          wr_en,
   input  ctl_entry_type      wr_entry,
   output logic               full,
   output logic               head_valid,
   output ctl_entry_type      head,
   input  wire logic          rd_en
);

   ctl_entry_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]          count_ff, count_in;

   assign full       = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

[rtl/ctl_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctl_back
// Back end: splits each queued entry into one or two token beats and holds
// the current token in an output register until it is popped.
// ----------------------------------------------------------------------------
module ctl_back import ctl_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          head_valid,
   input  ctl_entry_type      head,
   output logic               head_pop,
   output logic               empty,
   input  wire logic          pop,
   output logic [4:0]         token_kind,
   output logic [30:0]        number_value,
   output logic               number_saturated,
   output logic [63:0]        symbol_text,
   output logic [3:0]         symbol_length,
   output logic               symbol_truncated,
   output logic               last_of_run
);

   logic        valid_ff;
   logic        phase_ff, phase_in;
   logic        load;
   logic        take_a;
   logic [4:0]  kind_ff;
   logic [30:0] num_ff;
   logic        sat_ff;
   logic [63:0] text_ff;
   logic [3:0]  len_ff;
   logic        trunc_ff;
   logic        last_ff;

   assign load     = head_valid && (!valid_ff || pop);
   assign take_a   = !phase_ff && head.has_a;
   assign head_pop = load && !(take_a && head.has_b);

   always_comb begin
      phase_in = phase_ff;
      if (load) begin
         phase_in = take_a && head.has_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (load) begin
            valid_ff <= 1'b1;
         end else if (pop) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (take_a) begin
            kind_ff  <= head.a_kind;
            num_ff   <= head.a_num;
            sat_ff   <= head.a_sat;
            text_ff  <= head.a_text;
            len_ff   <= head.a_len;
            trunc_ff <= head.a_trunc;
            last_ff  <= !head.has_b;
         end else begin
            kind_ff  <= head.b_kind;
            num_ff   <= '0;
            sat_ff   <= 1'b0;
            text_ff  <= '0;
            len_ff   <= '0;
            trunc_ff <= 1'b0;
            last_ff  <= 1'b1;
         end
      end
   end

   assign empty            = !valid_ff;
   assign token_kind       = kind_ff;
   assign number_value     = num_ff;
   assign number_saturated = sat_ff;
   assign symbol_text      = text_ff;
   assign symbol_length    = len_ff;
   assign symbol_truncated = trunc_ff;
   assign last_of_run      = last_ff;

endmodule
`default_nettype wire

[rtl/c_token_lexer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// c_token_lexer
// Byte-serial lexer for a small C-like language: punctuators, comparison
// operators, saturating decimal numbers, identifiers and four keywords.
// ----------------------------------------------------------------------------
// path: a beat's tokens pass through the token queue into the output register
// throughput: one byte beat per cycle while the queue is not full; tokens leave
//   at one per cycle while popped, and a 4-entry queue absorbs two-token beats
// reset: synchronous; lexer returns to idle, queue and output register empty
// ----------------------------------------------------------------------------
module c_token_lexer import ctl_pkg::*; #(
   parameter int unsigned SYMBOL_CHARS = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   output logic               full,
   input  wire logic [7:0]    req_in_byte,
   input  wire logic          req_end_of_input,
   output logic               empty,
   input  wire logic          pop,
   output logic [4:0]         rsp_token_kind,
   output logic [30:0]        rsp_number_value,
   output logic               rsp_number_saturated,
   output logic [63:0]        rsp_symbol_text,
   output logic [3:0]         rsp_symbol_length,
   output logic               rsp_symbol_truncated,
   output logic               rsp_last_of_run
);

   ctl_entry_type entry;
   ctl_entry_type head;
   logic          entry_push;
   logic          head_valid;
   logic          head_pop;
   logic          accept;

   assign accept = push && !full;

   ctl_front #(
      .SYMBOL_CHARS (SYMBOL_CHARS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .in_byte      (req_in_byte),
      .end_of_input (req_end_of_input),
      .entry        (entry),
      .entry_push   (entry_push)
   );

   ctl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (entry_push),
      .wr_entry   (entry),
      .full       (full),
      .head_valid (head_valid),
      .head       (head),
      .rd_en      (head_pop)
   );

   ctl_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head             (head),
      .head_pop         (head_pop),
      .empty            (empty),
      .pop              (pop),
      .token_kind       (rsp_token_kind),
      .number_value     (rsp_number_value),
      .number_saturated (rsp_number_saturated),
      .symbol_text      (rsp_symbol_text),
      .symbol_length    (rsp_symbol_length),
      .symbol_truncated (rsp_symbol_truncated),
      .last_of_run      (rsp_last_of_run)
   );

endmodule
`default_nettype wire

[test/c_token_lexer_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// c_token_lexer_test
// Self-checking bench for the byte-serial C token lexer. A queue of byte and
// end-marker beats, directed first and then random token streams, is pushed
// through four flow-control phases. A behavioral lexer predicts the tokens of
// every accepted beat, and each popped token is compared with the oldest one
// still due.
// ----------------------------------------------------------------------------
module c_token_lexer_test import ctl_pkg::*; ();

   localparam int unsigned SYM_CHARS  = 8;
   localparam int          FEED_ITEMS = 1750;
   localparam int          TAIL_WAIT  = 20;

   typedef struct packed {
      logic [4:0]  kind;
      logic [30:0] num;
      logic        sat;
      logic [63:0] text;
      logic [3:0]  len;
      logic        trunc;
      logic        last;
   } token_type;

   typedef struct {
      logic [7:0] b;
      logic       eoi;
      int         phase;
      logic       drain;
   } feed_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_end_of_input = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic [4:0]  rsp_token_kind;
   logic [30:0] rsp_number_value;
   logic        rsp_number_saturated;
   logic [63:0] rsp_symbol_text;
   logic [3:0]  rsp_symbol_length;
   logic        rsp_symbol_truncated;
   logic        rsp_last_of_run;

   feed_item_type feed [$];
   token_type     tokens_due [$];
   int            mismatches = 0;
   int            cur_phase = 0;

   // stimulus generation state
   int         gen_phase = 0;
   logic       gen_drain = 1'b0;

   // lexer prediction state
   logic [2:0]  lx_mode = MODE_IDLE;
   logic [30:0] lx_acc = '0;
   logic        lx_clamped = 1'b0;
   logic [63:0] lx_sym = '0;
   logic [3:0]  lx_sym_len = '0;
   logic        lx_sym_over = 1'b0;
   token_type   step_toks [2];
   int          step_n;

   c_token_lexer #(.SYMBOL_CHARS(SYM_CHARS)) dut (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_in_byte          (req_in_byte),
      .req_end_of_input     (req_end_of_input),
      .empty                (empty),
      .pop                  (pop),
      .rsp_token_kind       (rsp_token_kind),
      .rsp_number_value     (rsp_number_value),
      .rsp_number_saturated (rsp_number_saturated),
      .rsp_symbol_text      (rsp_symbol_text),
      .rsp_symbol_length    (rsp_symbol_length),
      .rsp_symbol_truncated (rsp_symbol_truncated),
      .rsp_last_of_run      (rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------
   function automatic logic is_space(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_letter(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic [4:0] punct_of(logic [7:0] c);
      case (c)
         "+": return TK_PLUS;
         "-": return TK_MINUS;
         "*": return TK_STAR;
         "/": return TK_SLASH;
         "(": return TK_LPAREN;
         ")": return TK_RPAREN;
         "{": return TK_LBRACE;
         "}": return TK_RBRACE;
         "[": return TK_LBRACKET;
         "]": return TK_RBRACKET;
         ";": return TK_SEMI;
         default: return TK_END;
      endcase
   endfunction

   function automatic logic [63:0] pack_word(string s);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
      return v;
   endfunction

   function automatic token_type plain(logic [4:0] kind);
      token_type t;
      t = '0;
      t.kind = kind;
      return t;
   endfunction

   function automatic void stage(token_type t);
      if (step_n < 2) step_toks[step_n] = t;
      step_n++;
   endfunction

   function automatic void clear_lexer();
      lx_mode     = MODE_IDLE;
      lx_acc      = '0;
      lx_clamped  = 1'b0;
      lx_sym      = '0;
      lx_sym_len  = '0;
      lx_sym_over = 1'b0;
   endfunction

   // emits whatever token is pending in the current mode
   function automatic void flush_pending();
      token_type  t;
      logic [4:0] kind;
      string      words [4];
      logic [4:0] kinds [4];
      words = '{"print", "var", "return", "for"};
      kinds = '{TK_PRINT, TK_VAR, TK_RETURN, TK_FOR};
      case (lx_mode)
         MODE_EQ: stage(plain(TK_ASSIGN));
         MODE_LT: stage(plain(TK_LT));
         MODE_GT: stage(plain(TK_GT));
         MODE_BANG: stage(plain(TK_BANG));
         MODE_NUM: begin
            t = plain(TK_NUMBER);
            t.num = lx_acc;
            t.sat = lx_clamped;
            stage(t);
         end
         MODE_IDENT: begin
            kind = TK_IDENT;
            if (!lx_sym_over) begin
               for (int i = 0; i < 4; i++) begin
                  if (kind == TK_IDENT && int'(lx_sym_len) == words[i].len() &&
                      lx_sym == pack_word(words[i]))
                     kind = kinds[i];
               end
            end
            t = plain(kind);
            if (kind == TK_IDENT) begin
               t.text  = lx_sym;
               t.len   = lx_sym_len;
               t.trunc = lx_sym_over;
            end
            stage(t);
         end
         default: ;
      endcase
   endfunction

   // a byte seen with no token pending
   function automatic void start_byte(logic [7:0] c);
      lx_mode = MODE_IDLE;
      if (is_space(c)) begin
      end else if (punct_of(c) != TK_END) begin
         stage(plain(punct_of(c)));
      end else if (c == "=") begin
         lx_mode = MODE_EQ;
      end else if (c == "<") begin
         lx_mode = MODE_LT;
      end else if (c == ">") begin
         lx_mode = MODE_GT;
      end else if (c == "!") begin
         lx_mode = MODE_BANG;
      end else if (is_digit(c)) begin
         lx_mode    = MODE_NUM;
         lx_acc     = 31'(c - "0");
         lx_clamped = 1'b0;
      end else if (is_letter(c)) begin
         lx_mode     = MODE_IDENT;
         lx_sym      = {56'd0, c};
         lx_sym_len  = 4'd1;
         lx_sym_over = 1'b0;
      end else begin
         lx_mode = MODE_ERR;
         stage(plain(TK_ERROR));
      end
   endfunction

   // predicts the tokens of one accepted beat and queues them
   function automatic void lex_byte(logic [7:0] c, logic eoi);
      longint unsigned wide;
      token_type       t;
      step_n = 0;
      if (eoi) begin
         flush_pending();
         stage(plain(TK_END));
         clear_lexer();
      end else if (lx_mode == MODE_ERR) begin
      end else if (lx_mode == MODE_EQ || lx_mode == MODE_LT || lx_mode == MODE_GT ||
                   lx_mode == MODE_BANG) begin
         if (c == "=") begin
            case (lx_mode)
               MODE_EQ: stage(plain(TK_EQ_EQ));
               MODE_LT: stage(plain(TK_LT_EQ));
               MODE_GT: stage(plain(TK_GT_EQ));
               default: stage(plain(TK_NOT_EQ));
            endcase
            lx_mode = MODE_IDLE;
         end else begin
            flush_pending();
            start_byte(c);
         end
      end else if (lx_mode == MODE_NUM && is_digit(c)) begin
         wide = longint'(lx_acc) * 10 + longint'(c) - 48;
         if (wide > longint'(NUM_MAX)) begin
            wide       = longint'(NUM_MAX);
            lx_clamped = 1'b1;
         end
         lx_acc = 31'(wide);
      end else if (lx_mode == MODE_IDENT && is_letter(c)) begin
         if (int'(lx_sym_len) < SYM_CHARS) begin
            lx_sym[8*int'(lx_sym_len) +: 8] = c;
            lx_sym_len++;
         end else begin
            lx_sym_over = 1'b1;
         end
      end else begin
         flush_pending();
         start_byte(c);
      end
      for (int i = 0; i < step_n && i < 2; i++) begin
         t      = step_toks[i];
         t.last = (i == step_n - 1);
         tokens_due.push_back(t);
      end
   endfunction

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   function automatic int sender_idle_pct(int phase);
      return phase == 1 ? 64 : (phase == 3 ? 35 : 0);
   endfunction

   function automatic int receiver_stall_pct(int phase);
      return phase == 2 ? 64 : (phase == 3 ? 35 : 0);
   endfunction

   function automatic logic starts_token(logic [7:0] c);
      return is_space(c) || is_digit(c) || is_letter(c) || punct_of(c) != TK_END ||
             c == "=" || c == "<" || c == ">" || c == "!";
   endfunction

   function automatic void add_item(logic [7:0] b, logic eoi);
      feed_item_type it;
      it.b     = b;
      it.eoi   = eoi;
      it.phase = gen_phase;
      it.drain = gen_drain;
      gen_drain = 1'b0;
      feed.push_back(it);
   endfunction

   function automatic void add_byte(logic [7:0] b);
      add_item(b, 1'b0);
   endfunction

   function automatic void add_eoi();
      add_item(8'($urandom_range(255)), 1'b1);
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function automatic logic [7:0] rand_letter();
      return 8'(65 + $urandom_range(25) + ($urandom_range(1) ? 32 : 0));
   endfunction

   function automatic void add_random_lexeme();
      string      ws_set = " \t\n\013\014\r";
      string      punct_set = "+-*/(){}[];";
      string      op_set = "=<>!";
      string      words [4];
      string      w;
      int         pick;
      int         n;
      logic [7:0] c;
      words = '{"print", "var", "return", "for"};
      pick  = $urandom_range(99);
      if (pick < 12) begin
         add_byte(ws_set[$urandom_range(5)]);
      end else if (pick < 26) begin
         add_byte(punct_set[$urandom_range(10)]);
      end else if (pick < 37) begin
         add_byte(op_set[$urandom_range(3)]);
         if ($urandom_range(1)) add_byte("=");
      end else if (pick < 54) begin
         n = ($urandom_range(7) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4);
         for (int i = 0; i < n; i++) add_byte(8'("0" + $urandom_range(9)));
      end else if (pick < 70) begin
         n = ($urandom_range(6) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
         for (int i = 0; i < n; i++) add_byte(rand_letter());
      end else if (pick < 80) begin
         // keywords, exact or one letter off
         w = words[$urandom_range(3)];
         case ($urandom_range(3))
            0: w = w.substr(0, w.len() - 2);
            1: w = {w, "s"};
            default: ;
         endcase
         add_text(w);
      end else if (pick < 87) begin
         add_eoi();
      end else if (pick < 93) begin
         add_byte(8'($urandom_range(255)));
      end else begin
         // bad byte, some ignored bytes, then the end marker
         do c = 8'($urandom_range(255)); while (starts_token(c));
         add_byte(c);
         n = $urandom_range(0, 4);
         for (int i = 0; i < n; i++) add_byte(8'($urandom_range(255)));
         add_eoi();
      end
   endfunction

   // ------------------------------------------------------------------------
   // driver: one beat offered at a time, held until accepted
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      feed_item_type it;
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) lex_byte(req_in_byte, req_end_of_input);
         if (!push || !full) begin
            if (feed.size() != 0 && (!feed[0].drain || tokens_due.size() == 0) &&
                $urandom_range(99) >= sender_idle_pct(feed[0].phase)) begin
               it = feed.pop_front();
               push             <= 1'b1;
               req_in_byte      <= it.b;
               req_end_of_input <= it.eoi;
               cur_phase        <= it.phase;
            end else begin
               push             <= 1'b0;
               req_in_byte      <= 8'($urandom);
               req_end_of_input <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor: token beats against the oldest prediction
   // ------------------------------------------------------------------------
   function automatic string token_str(token_type t);
      return $sformatf("kind %0d num %0d sat %0b text %h len %0d trunc %0b last %0b",
                       t.kind, t.num, t.sat, t.text, t.len, t.trunc, t.last);
   endfunction

   always @(posedge clock) begin
      token_type got;
      token_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            got = {rsp_token_kind, rsp_number_value, rsp_number_saturated, rsp_symbol_text,
                   rsp_symbol_length, rsp_symbol_truncated, rsp_last_of_run};
            if (tokens_due.size() == 0) begin
               mismatches++;
               $display("%0t unexpected token: expected none, got %s", $time, token_str(got));
            end else begin
               want = tokens_due.pop_front();
               if (got !== want) begin
                  mismatches++;
                  $display("%0t token mismatch: expected %s, got %s", $time,
                           token_str(want), token_str(got));
               end
            end
         end
         pop <= ($urandom_range(99) >= receiver_stall_pct(cur_phase));
      end
   end

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      // error byte, ignored byte, end; then operators, keyword, clamped number
      add_byte(8'h00);
      add_byte(8'hFF);
      add_eoi();
      add_text("for<=4294967296!");
      add_eoi();
      for (int p = 0; p < 4; p++) begin
         gen_phase = p;
         gen_drain = 1'b1;
         while (feed.size() < (p + 1) * FEED_ITEMS / 4) add_random_lexeme();
      end
      add_eoi();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (feed.size() != 0 || push || tokens_due.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
      if (mismatches == 0 && tokens_due.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

[sim.f]
rtl/ctl_pkg.sv
rtl/ctl_front.sv
rtl/ctl_queue.sv
rtl/ctl_back.sv
rtl/c_token_lexer.sv
test/c_token_lexer_test.sv
